/* sv/bezier_easing_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_easing_pkg
// Shared constants, types and helpers for the cubic Bezier easing core.
// ----------------------------------------------------------------------------
package bezier_easing_pkg;

    // number format: unsigned fixed point, FRAC_BITS fraction bits
    localparam int FRAC_BITS      = 15;
    localparam int ITERATIONS_DEF = 12;

    localparam int DATA_W = 16;             // width of every payload field
    localparam int UNIT_W = FRAC_BITS + 1;  // holds [0, 1.0]
    localparam int ACC_W  = FRAC_BITS + 6;  // signed working range +-32.0
    localparam int PROD_W = ACC_W + UNIT_W + 1;

    localparam logic [UNIT_W-1:0] ONE_VAL  = UNIT_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_VAL = PROD_W'(1) << (FRAC_BITS - 1);

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int TOL_W      = 11;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);
    localparam logic REG_TOLERANCE = 1'b0;  // register index, paddr[2]

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_CHECK,
        ST_Y0,
        ST_Y1,
        ST_Y2,
        ST_Y3,
        ST_Y4,
        ST_Y5,
        ST_Y6,
        ST_DONE
    } bez_state_t;

    // saturate a raw field to [0, 1.0]
    function automatic logic [UNIT_W-1:0] sat_unit(logic [DATA_W-1:0] raw);
        logic [UNIT_W-1:0] v;
        v = UNIT_W'(raw);
        if (v > ONE_VAL) begin
            v = ONE_VAL;
        end
        return v;
    endfunction

    // zero-extend a unit value into the signed working width
    function automatic logic signed [ACC_W-1:0] unit_ext(logic [UNIT_W-1:0] v);
        return $signed({{(ACC_W - UNIT_W){1'b0}}, v});
    endfunction

    // clamp a signed working value to [0, 1.0]
    function automatic logic [UNIT_W-1:0] clamp_unit(logic signed [ACC_W-1:0] v);
        logic [UNIT_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > unit_ext(ONE_VAL)) begin
            r = ONE_VAL;
        end else begin
            r = v[UNIT_W-1:0];
        end
        return r;
    endfunction

endpackage

/* sv/bezier_easing_y_from_x_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_easing_y_from_x_core
// Cubic Bezier easing curve evaluation, y from x, on one shared multiplier.
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one request: progress x and the two inner control
//   points, all Q1.15 and saturated to 1.0 on entry. m_* channel returns the
//   eased y for that request, Q1.15 in [0, 1.0].
//   the APB port holds one register, tolerance (address 0, 11 bits); the user
//   must write it only while the core is idle; the core does not enforce this.
// sequencing:
//   one request at a time, every multiply on the single multiply-round-add
//   unit. an accepted request goes through a prep step, then per solver
//   iteration 3 multiplies plus the convergence test (at most ITERATIONS
//   iterations), then 7 multiplies for the y polynomial and finally the
//   load of the output register; diagonal control points skip the solver and
//   the polynomial. s_ready returns as the result is loaded, so the core
//   takes no new request before the last one has reached the output register.
// reset: aresetn (synchronous, active low) clears m_valid, returns the
//   sequencer to idle and sets tolerance to 16.
// stalls:
//   the result waits in the output register while m_ready is low; the core
//   still takes and works on the next request, holding it only at the final
//   step until the output register is free.
// ----------------------------------------------------------------------------
module bezier_easing_y_from_x_core #(
    parameter int ITERATIONS = bezier_easing_pkg::ITERATIONS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // request channel
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic [bezier_easing_pkg::DATA_W-1:0]       s_progress_x,
    input  logic [bezier_easing_pkg::DATA_W-1:0]       s_ctrl1_x,
    input  logic [bezier_easing_pkg::DATA_W-1:0]       s_ctrl1_y,
    input  logic [bezier_easing_pkg::DATA_W-1:0]       s_ctrl2_x,
    input  logic [bezier_easing_pkg::DATA_W-1:0]       s_ctrl2_y,
    // result channel
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [bezier_easing_pkg::DATA_W-1:0]       m_eased_y,
    // configuration port
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [bezier_easing_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bezier_easing_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bezier_easing_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                       pready
);

    localparam int UNIT_W = bezier_easing_pkg::UNIT_W;
    localparam int ACC_W  = bezier_easing_pkg::ACC_W;
    localparam int PROD_W = bezier_easing_pkg::PROD_W;
    localparam int FRAC   = bezier_easing_pkg::FRAC_BITS;
    localparam int TOL_W  = bezier_easing_pkg::TOL_W;
    localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERATIONS - 1);

    // sequencer
    bezier_easing_pkg::bez_state_t state_reg, state_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;

    // saturated request fields
    logic [UNIT_W-1:0]       x_reg, x_next;
    logic [UNIT_W-1:0]       c1x_reg, c1x_next;
    logic [UNIT_W-1:0]       c1y_reg, c1y_next;
    logic [UNIT_W-1:0]       c2x_reg, c2x_next;
    logic [UNIT_W-1:0]       c2y_reg, c2y_next;

    // x(t) polynomial coefficients
    logic signed [ACC_W-1:0] k0_reg, k0_next;
    logic signed [ACC_W-1:0] k1_reg, k1_next;
    logic signed [ACC_W-1:0] k2_reg, k2_next;

    // working values
    logic [UNIT_W-1:0]       t_reg, t_next;
    logic [UNIT_W-1:0]       t2_reg, t2_next;
    logic [UNIT_W-1:0]       r2_reg, r2_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] ysum_reg, ysum_next;

    // config and output
    logic [TOL_W-1:0]        tol_reg, tol_next;
    logic                    m_valid_reg, m_valid_next;
    logic [bezier_easing_pkg::DATA_W-1:0] m_y_reg, m_y_next;

    // shared multiply-round-add unit
    logic signed [ACC_W-1:0]  mul_a;
    logic [UNIT_W-1:0]        mul_b;
    logic signed [ACC_W-1:0]  add_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [ACC_W-1:0]  mac;

    // helpers
    logic signed [ACC_W-1:0] c1x_s, c2x_s;
    logic [UNIT_W-1:0]       r_val;
    logic signed [ACC_W-1:0] tol_s;
    logic signed [ACC_W-1:0] t_upd;
    logic                    converged;
    logic                    diag;
    logic                    cfg_wr;

    // rounded fixed-point product plus an addend, floor((a*b + 2^(F-1)) / 2^F) + c
    assign prod     = mul_a * $signed({1'b0, mul_b});
    assign prod_rnd = prod + $signed(bezier_easing_pkg::HALF_VAL);
    assign mac      = $signed(prod_rnd[ACC_W+FRAC-1:FRAC]) + add_op;

    assign c1x_s     = bezier_easing_pkg::unit_ext(c1x_reg);
    assign c2x_s     = bezier_easing_pkg::unit_ext(c2x_reg);
    assign r_val     = bezier_easing_pkg::ONE_VAL - t_reg;
    assign tol_s     = $signed({{(ACC_W - TOL_W){1'b0}}, tol_reg});
    // acc holds the x error in the check step
    assign converged = (acc_reg <= tol_s) && (acc_reg >= -tol_s);
    // damped step: t - floor(err / 2)
    assign t_upd     = bezier_easing_pkg::unit_ext(t_reg) - (acc_reg >>> 1);
    assign diag      = (c1x_reg == c1y_reg) && (c2x_reg == c2y_reg);

    // config write on the access phase
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bezier_easing_pkg::REG_TOLERANCE)
                  ? {{(bezier_easing_pkg::CFG_DATA_W - TOL_W){1'b0}}, tol_reg}
                  : '0;

    assign s_ready   = (state_reg == bezier_easing_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_eased_y = m_y_reg;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        x_next       = x_reg;
        c1x_next     = c1x_reg;
        c1y_next     = c1y_reg;
        c2x_next     = c2x_reg;
        c2y_next     = c2y_reg;
        k0_next      = k0_reg;
        k1_next      = k1_reg;
        k2_next      = k2_reg;
        t_next       = t_reg;
        t2_next      = t2_reg;
        r2_next      = r2_reg;
        acc_next     = acc_reg;
        ysum_next    = ysum_reg;
        tol_next     = tol_reg;
        m_valid_next = m_valid_reg;
        m_y_next     = m_y_reg;
        mul_a        = '0;
        mul_b        = '0;
        add_op       = '0;

        if (cfg_wr && paddr[2] == bezier_easing_pkg::REG_TOLERANCE) begin
            tol_next = pwdata[TOL_W-1:0];
        end

        // result taken by the receiver
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bezier_easing_pkg::ST_IDLE: begin
                if (s_valid) begin
                    x_next     = bezier_easing_pkg::sat_unit(s_progress_x);
                    c1x_next   = bezier_easing_pkg::sat_unit(s_ctrl1_x);
                    c1y_next   = bezier_easing_pkg::sat_unit(s_ctrl1_y);
                    c2x_next   = bezier_easing_pkg::sat_unit(s_ctrl2_x);
                    c2y_next   = bezier_easing_pkg::sat_unit(s_ctrl2_y);
                    state_next = bezier_easing_pkg::ST_PREP;
                end
            end
            bezier_easing_pkg::ST_PREP: begin
                // k0 = 1 + 3 c1x - 3 c2x, k1 = 3 c2x - 6 c1x, k2 = 3 c1x
                k0_next   = bezier_easing_pkg::unit_ext(bezier_easing_pkg::ONE_VAL)
                          + c1x_s + (c1x_s <<< 1) - c2x_s - (c2x_s <<< 1);
                k1_next   = c2x_s + (c2x_s <<< 1) - (c1x_s <<< 1) - (c1x_s <<< 2);
                k2_next   = c1x_s + (c1x_s <<< 1);
                t_next    = x_reg;
                iter_next = '0;
                if (diag) begin
                    // linear curve: y is x
                    ysum_next  = bezier_easing_pkg::unit_ext(x_reg);
                    state_next = bezier_easing_pkg::ST_DONE;
                end else begin
                    state_next = bezier_easing_pkg::ST_H0;
                end
            end
            bezier_easing_pkg::ST_H0: begin
                mul_a      = k0_reg;
                mul_b      = t_reg;
                add_op     = k1_reg;
                acc_next   = mac;
                state_next = bezier_easing_pkg::ST_H1;
            end
            bezier_easing_pkg::ST_H1: begin
                mul_a      = acc_reg;
                mul_b      = t_reg;
                add_op     = k2_reg;
                acc_next   = mac;
                state_next = bezier_easing_pkg::ST_H2;
            end
            bezier_easing_pkg::ST_H2: begin
                // x(t) - x
                mul_a      = acc_reg;
                mul_b      = t_reg;
                add_op     = -bezier_easing_pkg::unit_ext(x_reg);
                acc_next   = mac;
                state_next = bezier_easing_pkg::ST_CHECK;
            end
            bezier_easing_pkg::ST_CHECK: begin
                if (converged) begin
                    state_next = bezier_easing_pkg::ST_Y0;
                end else begin
                    t_next = bezier_easing_pkg::clamp_unit(t_upd);
                    if (iter_reg == ITER_LAST) begin
                        state_next = bezier_easing_pkg::ST_Y0;
                    end else begin
                        iter_next  = iter_reg + 1'b1;
                        state_next = bezier_easing_pkg::ST_H0;
                    end
                end
            end
            bezier_easing_pkg::ST_Y0: begin
                // t^2
                mul_a      = bezier_easing_pkg::unit_ext(t_reg);
                mul_b      = t_reg;
                t2_next    = mac[UNIT_W-1:0];
                state_next = bezier_easing_pkg::ST_Y1;
            end
            bezier_easing_pkg::ST_Y1: begin
                // t^3 opens the sum
                mul_a      = bezier_easing_pkg::unit_ext(t2_reg);
                mul_b      = t_reg;
                ysum_next  = mac;
                state_next = bezier_easing_pkg::ST_Y2;
            end
            bezier_easing_pkg::ST_Y2: begin
                // (1-t)^2
                mul_a      = bezier_easing_pkg::unit_ext(r_val);
                mul_b      = r_val;
                r2_next    = mac[UNIT_W-1:0];
                state_next = bezier_easing_pkg::ST_Y3;
            end
            bezier_easing_pkg::ST_Y3: begin
                mul_a      = bezier_easing_pkg::unit_ext(t2_reg);
                mul_b      = r_val;
                acc_next   = mac;
                state_next = bezier_easing_pkg::ST_Y4;
            end
            bezier_easing_pkg::ST_Y4: begin
                // + 3 t^2 (1-t) c2y
                mul_a      = acc_reg + (acc_reg <<< 1);
                mul_b      = c2y_reg;
                add_op     = ysum_reg;
                ysum_next  = mac;
                state_next = bezier_easing_pkg::ST_Y5;
            end
            bezier_easing_pkg::ST_Y5: begin
                mul_a      = bezier_easing_pkg::unit_ext(t_reg);
                mul_b      = r2_reg;
                acc_next   = mac;
                state_next = bezier_easing_pkg::ST_Y6;
            end
            bezier_easing_pkg::ST_Y6: begin
                // + 3 t (1-t)^2 c1y
                mul_a      = acc_reg + (acc_reg <<< 1);
                mul_b      = c1y_reg;
                add_op     = ysum_reg;
                ysum_next  = mac;
                state_next = bezier_easing_pkg::ST_DONE;
            end
            bezier_easing_pkg::ST_DONE: begin
                // wait for a free output register
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_y_next     = bezier_easing_pkg::DATA_W'(
                                       bezier_easing_pkg::clamp_unit(ysum_reg));
                    state_next   = bezier_easing_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bezier_easing_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bezier_easing_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            tol_reg     <= bezier_easing_pkg::TOL_RESET;
            iter_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tol_reg     <= tol_next;
            iter_reg    <= iter_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        c1x_reg  <= c1x_next;
        c1y_reg  <= c1y_next;
        c2x_reg  <= c2x_next;
        c2y_reg  <= c2y_next;
        k0_reg   <= k0_next;
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        t_reg    <= t_next;
        t2_reg   <= t2_next;
        r2_reg   <= r2_next;
        acc_reg  <= acc_next;
        ysum_reg <= ysum_next;
        m_y_reg  <= m_y_next;
    end

`ifndef ASSERT_OFF
    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while the previous one is in flight");

    // solver never runs past its iteration budget
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bezier_easing_pkg::ST_CHECK |-> iter_reg <= ITER_LAST)
        else $error("iteration counter beyond budget");

    // t stays inside the unit interval through the solver
    a_t_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bezier_easing_pkg::ST_CHECK |=> t_reg <= bezier_easing_pkg::ONE_VAL)
        else $error("curve parameter left [0, 1]");

    // a new result only comes out of the final step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bezier_easing_pkg::ST_DONE))
        else $error("result loaded outside the final step");

    // result is saturated to one
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_y_reg <= bezier_easing_pkg::DATA_W'(bezier_easing_pkg::ONE_VAL))
        else $error("result above one");
`endif

endmodule
